>>> hdl/sled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sled_pkg: shared types and constants of the string literal escape decoder
// Holds the decoder phase, the result status codes, the result record and
// the character codes that the escape logic looks for.
// ----------------------------------------------------------------------------
package sled_pkg;

  // decoder phase inside one literal body
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_OCT   = 2'd2,
    PH_HEX   = 2'd3
  } phase_e;

  // what a result beat carries
  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_CLOSED   = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_BADHEX   = 2'd3
  } status_e;

  // one result beat
  typedef struct packed {
    logic       last;
    status_e    status;
    logic [7:0] data;
  } result_t;

  // character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_X         = 8'h78;

  // named escapes, anything else passes through
  function automatic logic [7:0] named_escape(input logic [7:0] b);
    logic [7:0] v;
    begin
      unique case (b)
        8'h61:   v = 8'd7;   // a
        8'h62:   v = 8'd8;   // b
        8'h74:   v = 8'd9;   // t
        8'h6e:   v = 8'd10;  // n
        8'h76:   v = 8'd11;  // v
        8'h66:   v = 8'd12;  // f
        8'h72:   v = 8'd13;  // r
        8'h65:   v = 8'd27;  // e
        default: v = b;
      endcase
      return v;
    end
  endfunction

  // hex digit value, bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] v;
    begin
      if (b >= 8'h30 && b <= 8'h39) begin
        v = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
        v = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
        v = {1'b1, 4'(b - 8'h37)};
      end else begin
        v = 5'd0;
      end
      return v;
    end
  endfunction

endpackage

>>> hdl/string_literal_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_escape_decoder: C string literal body decoder
// Each accepted byte writes its result beats into the result queue, in order.
// Throughput: one byte per cycle while results drain; a byte that ends an
// octal or hex run with another result gives two output beats.
// Input stalls only when the four-entry result queue lacks two free slots.
// Reset clears the decode state and empties the result queue.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] status
  output logic       m_axis_tlast_o
);

  localparam int unsigned QDepth = 4;

  // decode state
  sled_pkg::phase_e phase_q, phase_d;
  logic [1:0]       ocnt_q, ocnt_d;
  logic [8:0]       val_q, val_d;
  logic             bad_q, bad_d;

  // result queue
  sled_pkg::result_t q_mem [QDepth];
  logic [1:0]        wr_ptr_q, rd_ptr_q;
  logic [2:0]        cnt_q;

  logic             in_beat, out_beat;
  logic [7:0]       b;
  logic [4:0]       hx;
  logic             is_oct;
  logic             bad_in;

  // plain body handler
  logic             p_emit, p_clear, p_esc;
  sled_pkg::status_e p_status;
  logic [7:0]       p_data;

  // pending value slot and plain slot
  logic             a_emit, use_plain;
  logic [7:0]       a_data;
  sled_pkg::status_e a_status;
  logic             b_emit;
  sled_pkg::result_t r0, r1;
  logic [1:0]       n_push;

  assign b       = s_axis_tdata_i;
  assign hx      = sled_pkg::hex_digit(b);
  assign is_oct  = (b[7:3] == 5'b00110);
  assign in_beat  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o & m_axis_tready_i;

  // a hex escape without digits is seen by its ending byte and then latched
  assign bad_in = bad_q | ((phase_q == sled_pkg::PH_HEX) && (ocnt_q == 2'd0));

  // plain body byte
  always_comb begin
    p_emit   = 1'b0;
    p_clear  = 1'b0;
    p_esc    = 1'b0;
    p_status = sled_pkg::ST_BYTE;
    p_data   = 8'd0;
    priority if (b == sled_pkg::CH_QUOTE) begin
      p_emit   = 1'b1;
      p_clear  = 1'b1;
      p_status = bad_in ? sled_pkg::ST_BADHEX : sled_pkg::ST_CLOSED;
    end else if (b == sled_pkg::CH_NEWLINE || b == sled_pkg::CH_NUL) begin
      p_emit   = 1'b1;
      p_clear  = 1'b1;
      p_status = sled_pkg::ST_UNCLOSED;
    end else if (b == sled_pkg::CH_BACKSLASH) begin
      p_esc = 1'b1;
    end else begin
      p_emit = 1'b1;
      p_data = b;
    end
  end

  // escape decoding and next state
  always_comb begin
    phase_d   = phase_q;
    ocnt_d    = ocnt_q;
    val_d     = val_q;
    bad_d     = bad_q;
    a_emit    = 1'b0;
    a_data    = 8'd0;
    a_status  = sled_pkg::ST_BYTE;
    use_plain = 1'b0;
    unique case (phase_q)
      sled_pkg::PH_PLAIN: begin
        use_plain = 1'b1;
      end
      sled_pkg::PH_ESC: begin
        priority if (b == sled_pkg::CH_NUL) begin
          a_emit   = 1'b1;
          a_status = sled_pkg::ST_UNCLOSED;
          phase_d  = sled_pkg::PH_PLAIN;
          ocnt_d   = 2'd0;
          val_d    = 9'd0;
          bad_d    = 1'b0;
        end else if (is_oct) begin
          phase_d = sled_pkg::PH_OCT;
          val_d   = {6'd0, b[2:0]};
          ocnt_d  = 2'd1;
        end else if (b == sled_pkg::CH_X) begin
          phase_d = sled_pkg::PH_HEX;
          val_d   = 9'd0;
          ocnt_d  = 2'd0;
        end else begin
          a_emit  = 1'b1;
          a_data  = sled_pkg::named_escape(b);
          phase_d = sled_pkg::PH_PLAIN;
        end
      end
      sled_pkg::PH_OCT: begin
        if (is_oct) begin
          if (ocnt_q == 2'd2) begin
            // third digit ends the escape at once
            a_emit  = 1'b1;
            a_data  = {val_q[4:0], b[2:0]};
            phase_d = sled_pkg::PH_PLAIN;
            ocnt_d  = 2'd0;
            val_d   = 9'd0;
          end else begin
            val_d  = {val_q[5:0], b[2:0]};
            ocnt_d = ocnt_q + 2'd1;
          end
        end else begin
          a_emit    = 1'b1;
          a_data    = val_q[7:0];
          use_plain = 1'b1;
        end
      end
      sled_pkg::PH_HEX: begin
        if (hx[4]) begin
          val_d  = {1'b0, val_q[3:0], hx[3:0]};
          ocnt_d = 2'd1;
        end else begin
          a_emit    = (ocnt_q != 2'd0);
          a_data    = val_q[7:0];
          use_plain = 1'b1;
        end
      end
      default: begin
        use_plain = 1'b1;
      end
    endcase
    // state left by the plain byte handler
    if (use_plain) begin
      ocnt_d = 2'd0;
      val_d  = 9'd0;
      bad_d  = bad_in;
      if (p_clear) begin
        phase_d = sled_pkg::PH_PLAIN;
        bad_d   = 1'b0;
      end else if (p_esc) begin
        phase_d = sled_pkg::PH_ESC;
      end else begin
        phase_d = sled_pkg::PH_PLAIN;
      end
    end
  end

  // order the results of this byte
  always_comb begin
    b_emit = use_plain & p_emit;
    n_push = {1'b0, a_emit} + {1'b0, b_emit};
    r1     = '{last: 1'b1, status: p_status, data: p_data};
    if (a_emit) begin
      r0 = '{last: ~b_emit, status: a_status, data: a_data};
    end else begin
      r0 = r1;
    end
  end

  // decode state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sled_pkg::PH_PLAIN;
      ocnt_q  <= 2'd0;
      val_q   <= 9'd0;
      bad_q   <= 1'b0;
    end else if (in_beat) begin
      phase_q <= phase_d;
      ocnt_q  <= ocnt_d;
      val_q   <= val_d;
      bad_q   <= bad_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (in_beat && (n_push != 2'd0)) begin
      q_mem[wr_ptr_q] <= r0;
      if (n_push == 2'd2) begin
        q_mem[wr_ptr_q + 2'd1] <= r1;
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (in_beat) begin
        wr_ptr_q <= wr_ptr_q + n_push;
      end
      if (out_beat) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (in_beat ? {1'b0, n_push} : 3'd0) - {2'd0, out_beat};
    end
  end

  // handshake and output beat
  assign s_axis_tready_o = (cnt_q <= 3'(QDepth - 2));
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tdata_o  = q_mem[rd_ptr_q].data;
  assign m_axis_tuser_o  = q_mem[rd_ptr_q].status;
  assign m_axis_tlast_o  = q_mem[rd_ptr_q].last;

endmodule

>>> hdl/sled_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sled_checker: port checks for the string literal escape decoder
// Watches the output stream for held beats, well-formed status beats and reset.
// ----------------------------------------------------------------------------
module sled_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // a stalled output beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // close and error beats are always the final beat of their byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != sled_pkg::ST_BYTE) |-> m_axis_tlast_o)
    else $error("status beat without last");

  // close and error beats carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != sled_pkg::ST_BYTE) |-> (m_axis_tdata_o == 8'd0))
    else $error("status beat with nonzero data");

  // no beat presented right after reset releases
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid out of reset");

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> tb/sv/tb_string_literal_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_literal_escape_decoder: self-checking bench for the literal decoder
// Feeds string literal bodies byte by byte: a directed set of escapes and
// error cases, then random literals, broken literals and raw noise. A
// byte-level predictor computes the expected result beats for each accepted
// byte, and the monitor checks every output beat against them. Traffic
// runs under several idle and stall mixes, including a long receiver hold.
// ----------------------------------------------------------------------------
module tb_string_literal_escape_decoder;

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_SEVEN = "7";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LO_A  = "a";
  localparam logic [7:0] CH_LO_F  = "f";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_F  = "F";
  localparam int         HOLD_CYCLES = 400;
  localparam int         DRAIN_CYCLES = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  string named_chars = "abtnvfre";
  string hex_chars   = "0123456789abcdefABCDEF";

  // predictor state for the current literal
  sled_pkg::phase_e lit_phase = sled_pkg::PH_PLAIN;
  logic [1:0]       digit_count = '0;
  logic [8:0]       esc_acc = '0;
  logic             hex_fault = 1'b0;

  sled_pkg::result_t step_beats[$];
  sled_pkg::result_t expected_beats[$];
  logic [7:0]        pending_bytes[$];

  int  bytes_queued = 0;
  int  bytes_taken = 0;
  bit  byte_taken = 1'b0;
  int  errors = 0;
  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  int  hold_asked = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  string_literal_escape_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor

  function automatic void clear_literal_state();
    lit_phase   = sled_pkg::PH_PLAIN;
    digit_count = '0;
    esc_acc     = '0;
    hex_fault   = 1'b0;
  endfunction

  function automatic void note_beat(logic [7:0] d, sled_pkg::status_e st);
    sled_pkg::result_t r;
    r.last   = 1'b0;
    r.status = st;
    r.data   = d;
    step_beats.push_back(r);
  endfunction

  function automatic bit is_octal(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

  // value of a hex digit, -1 for anything else
  function automatic int hex_nibble(logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
    if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] escaped_value(logic [7:0] b);
    case (b)
      "a":     return 8'd7;
      "b":     return 8'd8;
      "t":     return 8'd9;
      "n":     return 8'd10;
      "v":     return 8'd11;
      "f":     return 8'd12;
      "r":     return 8'd13;
      "e":     return 8'd27;
      default: return b;
    endcase
  endfunction

  // unescaped byte inside the body
  function automatic void body_byte(logic [7:0] b);
    if (b == sled_pkg::CH_QUOTE) begin
      note_beat(8'h00, hex_fault ? sled_pkg::ST_BADHEX : sled_pkg::ST_CLOSED);
      clear_literal_state();
    end else if (b == sled_pkg::CH_NEWLINE || b == sled_pkg::CH_NUL) begin
      note_beat(8'h00, sled_pkg::ST_UNCLOSED);
      clear_literal_state();
    end else if (b == sled_pkg::CH_BACKSLASH) begin
      lit_phase = sled_pkg::PH_ESC;
    end else begin
      note_beat(b, sled_pkg::ST_BYTE);
    end
  endfunction

  // expected beats for one accepted source byte
  function automatic void decode_byte(logic [7:0] b);
    int d;
    step_beats.delete();
    case (lit_phase)
      sled_pkg::PH_ESC: begin
        if (b == sled_pkg::CH_NUL) begin
          note_beat(8'h00, sled_pkg::ST_UNCLOSED);
          clear_literal_state();
        end else if (is_octal(b)) begin
          lit_phase   = sled_pkg::PH_OCT;
          esc_acc     = {6'd0, b[2:0]};
          digit_count = 2'd1;
        end else if (b == sled_pkg::CH_X) begin
          lit_phase   = sled_pkg::PH_HEX;
          esc_acc     = '0;
          digit_count = '0;
        end else begin
          note_beat(escaped_value(b), sled_pkg::ST_BYTE);
          lit_phase = sled_pkg::PH_PLAIN;
        end
      end
      sled_pkg::PH_OCT: begin
        if (is_octal(b)) begin
          esc_acc     = {esc_acc[5:0], b[2:0]};
          digit_count = digit_count + 2'd1;
          // third digit flushes the value right away
          if (digit_count == 2'd3) begin
            note_beat(esc_acc[7:0], sled_pkg::ST_BYTE);
            lit_phase   = sled_pkg::PH_PLAIN;
            digit_count = '0;
            esc_acc     = '0;
          end
        end else begin
          note_beat(esc_acc[7:0], sled_pkg::ST_BYTE);
          lit_phase   = sled_pkg::PH_PLAIN;
          digit_count = '0;
          esc_acc     = '0;
          body_byte(b);
        end
      end
      sled_pkg::PH_HEX: begin
        d = hex_nibble(b);
        if (d >= 0) begin
          esc_acc     = {1'b0, esc_acc[3:0], 4'(d)};
          digit_count = 2'd1;
        end else begin
          // no digits at all: latch the fault, report it at the close
          if (digit_count == 2'd0) hex_fault = 1'b1;
          else note_beat(esc_acc[7:0], sled_pkg::ST_BYTE);
          lit_phase   = sled_pkg::PH_PLAIN;
          digit_count = '0;
          esc_acc     = '0;
          body_byte(b);
        end
      end
      default: body_byte(b);
    endcase
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders

  task automatic add_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == sled_pkg::CH_QUOTE || b == sled_pkg::CH_BACKSLASH ||
           b == sled_pkg::CH_NEWLINE);
    return b;
  endfunction

  // random body content without the terminator
  task automatic add_body();
    int parts;
    int kind;
    parts = $urandom_range(0, 8);
    repeat (parts) begin
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        repeat ($urandom_range(1, 4)) add_byte(plain_char());
      end else if (kind < 9) begin
        add_byte(sled_pkg::CH_BACKSLASH);
        add_byte(named_chars[$urandom_range(0, 7)]);
      end else if (kind < 12) begin
        add_byte(sled_pkg::CH_BACKSLASH);
        repeat ($urandom_range(1, 3)) add_byte(CH_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind < 15) begin
        add_byte(sled_pkg::CH_BACKSLASH);
        add_byte(sled_pkg::CH_X);
        repeat ($urandom_range(1, 4)) add_byte(hex_chars[$urandom_range(0, 21)]);
      end else if (kind < 18) begin
        // any escaped nonzero byte, backslash-newline included
        add_byte(sled_pkg::CH_BACKSLASH);
        add_byte(($urandom_range(0, 3) == 0) ? sled_pkg::CH_NEWLINE
                                              : 8'($urandom_range(1, 255)));
      end else if (kind == 18) begin
        add_byte(sled_pkg::CH_BACKSLASH);
        add_byte(sled_pkg::CH_X);
      end else begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(128, 255)));
      end
    end
  endtask

  task automatic add_random_bytes(int nbytes);
    int target;
    int r;
    target = bytes_queued + nbytes;
    while (bytes_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_body();
        add_byte(sled_pkg::CH_QUOTE);
      end else if (r < 88) begin
        add_body();
        case ($urandom_range(0, 3))
          0: add_byte(sled_pkg::CH_NEWLINE);
          1: add_byte(sled_pkg::CH_NUL);
          2: begin
            add_byte(sled_pkg::CH_BACKSLASH);
            add_byte(sled_pkg::CH_NUL);
          end
          default: begin
            add_byte(sled_pkg::CH_BACKSLASH);
            add_byte(CH_ZERO + 8'($urandom_range(0, 7)));
            add_byte(sled_pkg::CH_NUL);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // sender pause until every byte is taken and every result has come
  task automatic wait_drained();
    do @(negedge clk_i);
    while (bytes_taken != bytes_queued || expected_beats.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || byte_taken)) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom_range(0, 255));
      end
    end
  end

  // output ready, with a long hold when one is asked for
  always @(negedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_seen + 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // monitor: check result beats, predict on accepted input beats
  always @(posedge clk_i) begin
    sled_pkg::result_t want;
    byte_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual data %h status %0d last %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tdata !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.data, m_axis_tdata);
          end
          if (m_axis_tuser !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          end
          if (m_axis_tlast !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
          end
        end
      end
      if (byte_taken) begin
        bytes_taken++;
        decode_byte(s_axis_tdata);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, escapes, error precedence
    add_byte(8'hff);
    add_byte(8'h01);
    add_byte(sled_pkg::CH_QUOTE);
    add_text("\\e\\x4f1\\7774\\x\"");
    add_byte(sled_pkg::CH_BACKSLASH);
    add_byte(sled_pkg::CH_NUL);
    add_text("\\x\n");
    add_text("\\7");
    add_byte(sled_pkg::CH_NUL);
    wait_drained();

    // random traffic under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          hold_asked         = hold_asked + 1;
        end
        1: begin
          sender_idle_pct    = 83;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 83;
        end
        default: begin
          sender_idle_pct    = 38;
          receiver_stall_pct = 38;
        end
      endcase
      add_random_bytes(250);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("string_literal_escape_decoder: match");
    end else begin
      $display("string_literal_escape_decoder: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("string_literal_escape_decoder: mismatch");
    $finish;
  end

endmodule
